// File: rtl/rvwe_pkg.sv
// ----------------------------------------------------------------------------
// rvwe_pkg
// Shared widths, constants, the CORDIC arctangent table and the item
// sideband type of the rotated vector weight expander.
// ----------------------------------------------------------------------------
package rvwe_pkg;

  localparam int IDX_W    = 20;   // cell index width
  localparam int COL_W    = 21;   // column and cell count width
  localparam int VAL_W    = 18;   // signed Q2.16 weight and value
  localparam int ANG_W    = 16;   // angle, fraction of a full turn
  localparam int PH_W     = 32;   // CORDIC phase and datapath width
  localparam int STAGES   = 16;   // CORDIC iterations
  localparam int FRAC_SH  = 30;   // scale of cos and sin
  localparam int PROD_W   = VAL_W + PH_W;
  localparam int QUOT_W   = PROD_W - FRAC_SH;

  // Reset value of the source cell count.
  localparam logic [COL_W-1:0] COUNT_RESET = COL_W'(1048576);

  // One eighth of a turn, used to round the angle to the nearest quadrant.
  localparam logic [ANG_W-1:0] ANG_EIGHTH = ANG_W'(1 << (ANG_W - 3));

  // CORDIC start value: the inverse gain times 2^30.
  localparam logic signed [PH_W-1:0] CORDIC_X0 = 32'sd652032874;

  // Rounding offset and saturation bounds of the scaled value.
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_SH - 1);
  localparam logic signed [QUOT_W-1:0] VALUE_MAX  = QUOT_W'(131071);
  localparam logic signed [QUOT_W-1:0] VALUE_MIN  = -QUOT_W'(131072);

  // Target matrix codes.
  localparam logic MAT_U = 1'b0;
  localparam logic MAT_V = 1'b1;

  // Sideband that travels with an item through the CORDIC pipeline.
  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        src;
    logic [COL_W-1:0]        col_v;
    logic                    err;
    logic signed [VAL_W-1:0] weight;
    logic [1:0]              quad;
  } meta_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic signed [PH_W-1:0] atan_turn(input int unsigned i);
    logic signed [PH_W-1:0] a;
    case (i)
      0:  a = 32'sd536870912;
      1:  a = 32'sd316933406;
      2:  a = 32'sd167458907;
      3:  a = 32'sd85004757;
      4:  a = 32'sd42667331;
      5:  a = 32'sd21354465;
      6:  a = 32'sd10679838;
      7:  a = 32'sd5340245;
      8:  a = 32'sd2670163;
      9:  a = 32'sd1335087;
      10: a = 32'sd667544;
      11: a = 32'sd333772;
      12: a = 32'sd166886;
      13: a = 32'sd83443;
      14: a = 32'sd41721;
      15: a = 32'sd20861;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/rvwe_cordic.sv
// ----------------------------------------------------------------------------
// rvwe_cordic
// Pipelined rotation-mode CORDIC, one iteration per register stage, followed
// by a stage that restores the quadrant. All stages move on one enable.
// ----------------------------------------------------------------------------
module rvwe_cordic
  import rvwe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic signed [PH_W-1:0] in_z,
  input  meta_t                  in_meta,
  output logic                   out_valid,
  output logic signed [PH_W-1:0] out_cos,
  output logic signed [PH_W-1:0] out_sin,
  output meta_t                  out_meta
);

  // Stage registers; entry i holds the state after iteration i.
  logic                   vld [0:STAGES-1];
  logic signed [PH_W-1:0] xs  [0:STAGES-1];
  logic signed [PH_W-1:0] ys  [0:STAGES-1];
  logic signed [PH_W-1:0] zs  [0:STAGES-1];
  meta_t                  ms  [0:STAGES-1];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic                   vi;
    logic signed [PH_W-1:0] xi, yi, zi;
    meta_t                  mi;

    // The first iteration starts from the constant vector.
    if (i == 0) begin : g_first
      assign vi = in_valid;
      assign xi = CORDIC_X0;
      assign yi = '0;
      assign zi = in_z;
      assign mi = in_meta;
    end else begin : g_next
      assign vi = vld[i-1];
      assign xi = xs[i-1];
      assign yi = ys[i-1];
      assign zi = zs[i-1];
      assign mi = ms[i-1];
    end

    // Valid bit of the stage.
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vi;
      end
    end

    // One micro-rotation toward zero residual angle.
    always_ff @(posedge clk) begin
      if (en) begin
        ms[i] <= mi;
        if (!zi[PH_W-1]) begin
          xs[i] <= xi - (yi >>> i);
          ys[i] <= yi + (xi >>> i);
          zs[i] <= zi - atan_turn(i);
        end else begin
          xs[i] <= xi + (yi >>> i);
          ys[i] <= yi - (xi >>> i);
          zs[i] <= zi + atan_turn(i);
        end
      end
    end
  end

  // Quadrant restore by exact swaps and negations.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_meta <= ms[STAGES-1];
      case (ms[STAGES-1].quad)
        2'd0: begin
          out_cos <= xs[STAGES-1];
          out_sin <= ys[STAGES-1];
        end
        2'd1: begin
          out_cos <= -ys[STAGES-1];
          out_sin <= xs[STAGES-1];
        end
        2'd2: begin
          out_cos <= -xs[STAGES-1];
          out_sin <= -ys[STAGES-1];
        end
        default: begin
          out_cos <= ys[STAGES-1];
          out_sin <= -xs[STAGES-1];
        end
      endcase
    end
  end

endmodule

// File: rtl/rvwe_expand.sv
// ----------------------------------------------------------------------------
// rvwe_expand
// Turns one rotated item into four weighted entries: an entry register, a
// multiply stage and a rounding and saturating output register.
// ----------------------------------------------------------------------------
module rvwe_expand
  import rvwe_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [PH_W-1:0]  in_cos,
  input  logic signed [PH_W-1:0]  in_sin,
  input  meta_t                   in_meta,
  output logic                    in_take,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    target_matrix,
  output logic [IDX_W-1:0]        row,
  output logic [COL_W-1:0]        column,
  output logic signed [VAL_W-1:0] value,
  output logic                    last,
  output logic                    index_error
);

  // Entry order within one item.
  typedef enum logic [1:0] {
    ENT_U_COS = 2'd0,
    ENT_U_SIN = 2'd1,
    ENT_V_NSIN = 2'd2,
    ENT_V_COS = 2'd3
  } entry_t;

  // Held item and entry counter.
  logic                   hv;
  logic signed [PH_W-1:0] hc, hs;
  meta_t                  hm;
  entry_t                 cnt;

  // Multiply stage.
  logic                     mv;
  logic signed [PROD_W-1:0] prod;
  logic                     m_mat, m_last, m_err;
  logic [IDX_W-1:0]         m_row;
  logic [COL_W-1:0]         m_col;

  logic                     o_en, m_en, emit, done;
  logic signed [PH_W-1:0]   t_sel;
  logic signed [PROD_W-1:0] rsum;
  logic signed [QUOT_W-1:0] quot;
  logic signed [VAL_W-1:0]  sat;

  // Flow control from the output side back to the held item.
  assign o_en    = !out_valid || out_ready;
  assign m_en    = !mv || o_en;
  assign emit    = hv && m_en;
  assign done    = emit && (cnt == ENT_V_COS);
  assign in_take = !hv || done;

  // Factor for the current entry.
  always_comb begin
    case (cnt)
      ENT_U_COS:  t_sel = hc;
      ENT_U_SIN:  t_sel = hs;
      ENT_V_NSIN: t_sel = -hs;
      ENT_V_COS:  t_sel = hc;
      default:    t_sel = hc;
    endcase
  end

  // Round half up, then saturate to the value range.
  always_comb begin
    rsum = prod + ROUND_HALF;
    quot = QUOT_W'(rsum >>> FRAC_SH);
    if (quot > VALUE_MAX) begin
      sat = VAL_W'(VALUE_MAX);
    end else if (quot < VALUE_MIN) begin
      sat = VAL_W'(VALUE_MIN);
    end else begin
      sat = VAL_W'(quot);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      hv        <= 1'b0;
      cnt       <= ENT_U_COS;
      mv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        hv  <= in_valid;
        cnt <= ENT_U_COS;
      end else if (emit) begin
        cnt <= entry_t'(cnt + 2'd1);
      end
      if (m_en) begin
        mv <= emit;
      end
      if (o_en) begin
        out_valid <= mv;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take && in_valid) begin
      hc <= in_cos;
      hs <= in_sin;
      hm <= in_meta;
    end
    if (emit) begin
      prod   <= PROD_W'(hm.weight) * PROD_W'(t_sel);
      m_mat  <= cnt[1] ? MAT_V : MAT_U;
      m_col  <= cnt[0] ? hm.col_v : {1'b0, hm.src};
      m_row  <= hm.row;
      m_last <= (cnt == ENT_V_COS);
      m_err  <= hm.err;
    end
    if (o_en && mv) begin
      target_matrix <= m_mat;
      row           <= m_row;
      column        <= m_col;
      value         <= sat;
      last          <= m_last;
      index_error   <= m_err;
    end
  end

endmodule

// File: rtl/rotated_vector_weight_expander_unit.sv
// Result channel: the four entries of an item share the single result channel,
// so the expander takes a new item only after the last entry of the one it holds.
// Reset: rst is synchronous, active high; it empties the pipeline and sets the
// source cell count to 1048576. No memory clearing pass follows reset.
// ----------------------------------------------------------------------------
// rotated_vector_weight_expander_unit
// Rotates a scalar interpolation weight by the angle between the destination
// and the source cell and emits the four u and v matrix entries.
// ----------------------------------------------------------------------------
module rotated_vector_weight_expander_unit
  import rvwe_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [COL_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [IDX_W-1:0]        dst_index,
  input  logic [IDX_W-1:0]        src_index,
  input  logic signed [VAL_W-1:0] weight,
  input  logic [ANG_W-1:0]        src_angle,
  input  logic [ANG_W-1:0]        dst_angle,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    target_matrix,
  output logic [IDX_W-1:0]        row,
  output logic [COL_W-1:0]        column,
  output logic signed [VAL_W-1:0] value,
  output logic                    last,
  output logic                    index_error
);

  logic [COL_W-1:0]       source_cell_count;
  logic                   adv;
  logic                   s0_valid;
  logic signed [PH_W-1:0] s0_z;
  meta_t                  s0_meta;

  logic [ANG_W-1:0]       diff, qsum;
  logic [1:0]             quad;
  logic [PH_W-1:0]        resid;

  logic                   c_valid;
  logic signed [PH_W-1:0] c_cos, c_sin;
  meta_t                  c_meta;
  logic                   x_take;

  // Source cell count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_cell_count <= COUNT_RESET;
    end else if (cfg_we) begin
      source_cell_count <= cfg_wdata;
    end
  end

  // The item pipeline moves whenever its head is empty or is taken.
  assign adv      = !c_valid || x_take;
  assign in_ready = adv;

  // Angle difference, nearest quadrant and signed residual phase.
  always_comb begin
    diff  = dst_angle - src_angle;
    qsum  = diff + ANG_EIGHTH;
    quad  = qsum[ANG_W-1 -: 2];
    resid = {diff, {(PH_W-ANG_W){1'b0}}} - {quad, {(PH_W-2){1'b0}}};
  end

  // Input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_z           <= resid;
      s0_meta.row    <= dst_index;
      s0_meta.src    <= src_index;
      s0_meta.col_v  <= {1'b0, src_index} + source_cell_count;
      s0_meta.err    <= ({1'b0, src_index} >= source_cell_count);
      s0_meta.weight <= weight;
      s0_meta.quad   <= quad;
    end
  end

  // Cosine and sine of the angle difference.
  rvwe_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s0_valid),
    .in_z      (s0_z),
    .in_meta   (s0_meta),
    .out_valid (c_valid),
    .out_cos   (c_cos),
    .out_sin   (c_sin),
    .out_meta  (c_meta)
  );

  // Four weighted entries per item.
  rvwe_expand u_expand (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (c_valid),
    .in_cos        (c_cos),
    .in_sin        (c_sin),
    .in_meta       (c_meta),
    .in_take       (x_take),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .target_matrix (target_matrix),
    .row           (row),
    .column        (column),
    .value         (value),
    .last          (last),
    .index_error   (index_error)
  );

endmodule
